FILE: hw/rtl/slir_pkg.sv
// package of shared types and constants for the sorted list store
`default_nettype none
package slir_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned TotalW   = 5;
  localparam int unsigned WideW    = (CntW > TotalW) ? CntW : TotalW;
  localparam int unsigned ValW     = 32;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2
  } status_e;

  typedef enum logic {
    ReqInsert = 1'b0,
    ReqRemove = 1'b1
  } req_e;

  // one stored entry
  typedef struct packed {
    logic                   valid;
    logic signed [ValW-1:0] value;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic                   found;
    logic signed [ValW-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/slir_cell.sv
// one cell of the sorted chain: holds an entry and trades it with its neighbours
`default_nettype none
module slir_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire slir_pkg::cmd_t                  cmd_i,
  input  wire slir_pkg::slot_t                 left_slot_i,
  input  wire logic                            left_less_i,
  input  wire slir_pkg::slot_t                 right_slot_i,
  output slir_pkg::slot_t                      slot_o,
  output slir_pkg::slot_t                      slot_next_o,
  output logic                                 less_o,
  output logic                                 eq_o
);

  logic                             valid_q, valid_d;
  logic signed [slir_pkg::ValW-1:0] value_q, value_d;

  assign less_o = valid_q && (value_q < cmd_i.value);
  assign eq_o   = valid_q && (value_q == cmd_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.ins && !less_o) begin
      if (left_less_i) begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
      end else begin
        valid_d = left_slot_i.valid;
        value_d = left_slot_i.value;
      end
    end else if (cmd_i.rem && cmd_i.found && valid_q && !less_o) begin
      // at or past the first match, close the gap from the right
      valid_d = right_slot_i.valid;
      value_d = right_slot_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign slot_o      = '{valid: valid_q, value: value_q};
  assign slot_next_o = '{valid: valid_d, value: value_d};

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_list_insert_remove_top.sv
// top level of the sorted list store: row of cells, entry count and result register
// the result strobe is registered and rises in the cycle after an accepted request
// throughput: one request per cycle, busy stays low; every cell updates in parallel
// from its own compare and its neighbours' entries, the match flag is a reduction tree
// reset: the count and all entry valid flags clear, so the list starts empty
// results cannot be stalled by the receiver
`default_nettype none
module sorted_list_insert_remove_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            req_type_i,
  input  wire logic signed [slir_pkg::ValW-1:0] value_i,
  output logic                                 valid_o,
  output logic [1:0]                           status_o,
  output logic [slir_pkg::TotalW-1:0]          entry_total_o,
  output logic signed [slir_pkg::ValW-1:0]     smallest_o
);

  localparam int unsigned N = slir_pkg::Capacity;

  slir_pkg::cmd_t  cmd;
  slir_pkg::slot_t slot      [N];
  slir_pkg::slot_t slot_next [N];
  logic [N-1:0]    less;
  logic [N-1:0]    eq;

  logic                          accept;
  logic                          full;
  logic                          found;
  logic [slir_pkg::CntW-1:0]     count_q, count_d;
  slir_pkg::status_e             status;
  logic [slir_pkg::WideW-1:0]    total_wide;

  logic                             valid_q;
  slir_pkg::status_e                status_q;
  logic [slir_pkg::TotalW-1:0]      total_q;
  logic signed [slir_pkg::ValW-1:0] smallest_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == slir_pkg::CntW'(N));
  assign found  = |eq;

  assign cmd.ins   = accept && (req_type_i == slir_pkg::ReqInsert) && !full;
  assign cmd.rem   = accept && (req_type_i == slir_pkg::ReqRemove);
  assign cmd.found = found;
  assign cmd.value = value_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    slir_pkg::slot_t left_slot;
    slir_pkg::slot_t right_slot;
    logic            left_less;

    if (i == 0) begin : g_head
      assign left_slot = '{valid: 1'b0, value: '0};
      assign left_less = 1'b1;
    end else begin : g_body
      assign left_slot = slot[i-1];
      assign left_less = less[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_slot = '{valid: 1'b0, value: '0};
    end else begin : g_inner
      assign right_slot = slot[i+1];
    end

    slir_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i        (cmd),
      .left_slot_i  (left_slot),
      .left_less_i  (left_less),
      .right_slot_i (right_slot),
      .slot_o       (slot[i]),
      .slot_next_o  (slot_next[i]),
      .less_o       (less[i]),
      .eq_o         (eq[i])
    );
  end

  always_comb begin
    count_d = count_q;
    status  = slir_pkg::StatusOk;
    if (accept) begin
      unique case (req_type_i)
        slir_pkg::ReqInsert: begin
          if (full) begin
            status = slir_pkg::StatusFull;
          end else begin
            count_d = count_q + slir_pkg::CntW'(1);
          end
        end
        slir_pkg::ReqRemove: begin
          if (!found) begin
            status = slir_pkg::StatusNotFound;
          end else begin
            count_d = count_q - slir_pkg::CntW'(1);
          end
        end
        default: status = slir_pkg::StatusOk;
      endcase
    end
  end

  // count is reported masked to the field width
  assign total_wide = slir_pkg::WideW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status;
      total_q    <= total_wide[slir_pkg::TotalW-1:0];
      smallest_q <= slot_next[0].valid ? slot_next[0].value : '0;
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;
  assign smallest_o    = smallest_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slir_pkg::CntW'(N))
    else $error("entry count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot[0].valid == (count_q != '0))
    else $error("head cell valid flag disagrees with count");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot[N-1].valid == full)
    else $error("tail cell valid flag disagrees with full");

  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted transaction gave no result");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rem == 1'b0) && !cmd.ins |=> $stable(count_q))
    else $error("count moved without a transaction");

endmodule
`default_nettype wire
